/* hw/rtl/lbps_pkg.sv */
// Shared types and constants for the LED and buzzer pattern sequencer.
// Holds the event kind and system mode codes, the indicator struct and the pattern timings.
// No dependencies.
package lbps_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    // Pattern timings in millisecond ticks
    localparam int BEEP_STEP  = 100;   // triple beep slot length
    localparam int TRIPLE_END = 600;
    localparam int WARN_ON    = 800;
    localparam int WARN_END   = 1000;
    localparam int KEY_ON     = 50;
    localparam int KEY_END    = 100;
    localparam int BEAT_ON    = 200;
    localparam int BEAT_END   = 3000;
    localparam int ALT_ON     = 200;
    localparam int ALT_END    = 400;
    localparam int BLINK_STEP = 50;
    localparam int BLINK_END  = 300;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_EVAL  = 2'd1,
        KIND_WRITE = 2'd2
    } lbps_kind_t;

    typedef enum logic [2:0] {
        MODE_READY   = 3'd0,
        MODE_NORMAL  = 3'd1,
        MODE_WARNING = 3'd2,
        MODE_OK      = 3'd3,
        MODE_KEY     = 3'd4
    } lbps_mode_t;

    // Indicator levels plus the system mode
    typedef struct packed {
        logic       buzzer;
        logic       led_one;
        logic       led_two;
        lbps_mode_t mode;
    } lbps_ind_t;

endpackage

/* hw/rtl/lbps_eval.sv */
// Next-state logic of the sequencer: applies one request to counters, levels and mode.
// Purely combinational; depends on lbps_pkg.
module lbps_eval
    import lbps_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic [1:0]             kind,
    input  logic [2:0]             new_system_state,
    input  logic [COUNT_WIDTH-1:0] buzzer_ticks,
    input  logic [COUNT_WIDTH-1:0] led_ticks,
    input  lbps_ind_t              ind,
    output logic [COUNT_WIDTH-1:0] buzzer_ticks_next,
    output logic [COUNT_WIDTH-1:0] led_ticks_next,
    output lbps_ind_t              ind_next
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    function automatic logic [COUNT_WIDTH-1:0] cv(input int v);
        return COUNT_WIDTH'(v);
    endfunction

    always_comb
    begin
        logic [COUNT_WIDTH-1:0] bt;
        logic [COUNT_WIDTH-1:0] lt;
        bt = buzzer_ticks;
        lt = led_ticks;
        buzzer_ticks_next = buzzer_ticks;
        led_ticks_next    = led_ticks;
        ind_next          = ind;

        unique case (kind)
            KIND_TICK:
            begin
                // saturate at all ones
                if (buzzer_ticks != CNT_MAX)
                    buzzer_ticks_next = buzzer_ticks + COUNT_WIDTH'(1);
                if (led_ticks != CNT_MAX)
                    led_ticks_next = led_ticks + COUNT_WIDTH'(1);
            end
            KIND_EVAL:
            begin
                // LED pattern; levels hold in the gaps
                unique case (ind.mode)
                    MODE_WARNING:
                    begin
                        if (lt < cv(ALT_ON))
                        begin
                            ind_next.led_one = 1'b1;
                            ind_next.led_two = 1'b0;
                        end
                        else if (lt < cv(ALT_END))
                        begin
                            ind_next.led_one = 1'b0;
                            ind_next.led_two = 1'b1;
                        end
                        if (lt > cv(ALT_END))
                            led_ticks_next = '0;
                    end
                    MODE_OK:
                    begin
                        // first LED toggles every blink step, starting lit
                        if (lt < cv(BLINK_STEP))              ind_next.led_one = 1'b1;
                        else if (lt < cv(2 * BLINK_STEP))     ind_next.led_one = 1'b0;
                        else if (lt < cv(3 * BLINK_STEP))     ind_next.led_one = 1'b1;
                        else if (lt < cv(4 * BLINK_STEP))     ind_next.led_one = 1'b0;
                        else if (lt < cv(5 * BLINK_STEP))     ind_next.led_one = 1'b1;
                        else if (lt < cv(BLINK_END))          ind_next.led_one = 1'b0;
                        if (lt > cv(BLINK_END))
                            led_ticks_next = '0;
                    end
                    default:
                    begin
                        if (lt < cv(BEAT_ON))
                        begin
                            ind_next.led_one = 1'b1;
                            ind_next.led_two = 1'b0;
                        end
                        else if (lt < cv(BEAT_END))
                        begin
                            ind_next.led_one = 1'b0;
                            ind_next.led_two = 1'b0;
                        end
                        if (lt > cv(BEAT_END))
                            led_ticks_next = '0;
                    end
                endcase

                // buzzer pattern; a finished sequence drops back to normal
                unique case (ind.mode)
                    MODE_READY, MODE_OK:
                    begin
                        if (bt < cv(BEEP_STEP))           ind_next.buzzer = 1'b1;
                        else if (bt < cv(2 * BEEP_STEP))  ind_next.buzzer = 1'b0;
                        else if (bt < cv(3 * BEEP_STEP))  ind_next.buzzer = 1'b1;
                        else if (bt < cv(4 * BEEP_STEP))  ind_next.buzzer = 1'b0;
                        else if (bt < cv(5 * BEEP_STEP))  ind_next.buzzer = 1'b1;
                        else if (bt < cv(TRIPLE_END))     ind_next.buzzer = 1'b0;
                        if (bt > cv(TRIPLE_END))
                            ind_next.mode = MODE_NORMAL;
                    end
                    MODE_WARNING:
                    begin
                        if (bt < cv(WARN_ON))
                            ind_next.buzzer = 1'b1;
                        else if (bt < cv(WARN_END))
                            ind_next.buzzer = 1'b0;
                        if (bt > cv(WARN_END))
                            ind_next.mode = MODE_NORMAL;
                    end
                    MODE_KEY:
                    begin
                        if (bt < cv(KEY_ON))
                            ind_next.buzzer = 1'b1;
                        else if (bt < cv(KEY_END))
                            ind_next.buzzer = 1'b0;
                        if (bt > cv(KEY_END))
                            ind_next.mode = MODE_NORMAL;
                    end
                    default:
                    begin
                        // normal: silence and restart the buzzer count
                        ind_next.buzzer   = 1'b0;
                        buzzer_ticks_next = '0;
                    end
                endcase
            end
            KIND_WRITE:
            begin
                // unknown codes leave the mode alone
                if (new_system_state <= MODE_KEY)
                    ind_next.mode = lbps_mode_t'(new_system_state);
            end
            default:
            begin
                // unused kind: no change
            end
        endcase
    end

endmodule

/* hw/rtl/led_buzzer_pattern_sequencer_unit.sv */
// Top level of the LED and buzzer pattern sequencer: request and result registers,
// sequencer state. Depends on lbps_pkg and lbps_eval.
//
// Each request is a millisecond tick, an evaluate step or a write of the system
// state, and gives exactly one result: the buzzer and LED levels and the system
// state as they stand after the request. A request is registered when taken; from
// the request register lbps_eval applies it to the sequencer state, and the result
// register loads at the same edge as the state once the result slot is free, so the
// result passes through the request register and then the result register.
// One request is taken every cycle; the only thing that can hold the
// request side is a full result register whose result is stalled downstream.
// Tick counters are COUNT_WIDTH bits wide and saturate.
module led_buzzer_pattern_sequencer_unit
    import lbps_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [1:0] kind,
    input  logic [2:0] new_system_state,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic       buzzer_on,
    output logic       led_one_on,
    output logic       led_two_on,
    output logic [2:0] system_state_now
);

    // request register
    logic       req_vld_reg;
    logic [1:0] kind_reg;
    logic [2:0] new_state_reg;

    // sequencer state
    logic [COUNT_WIDTH-1:0] buzzer_ticks_reg;
    logic [COUNT_WIDTH-1:0] led_ticks_reg;
    logic [COUNT_WIDTH-1:0] buzzer_ticks_next;
    logic [COUNT_WIDTH-1:0] led_ticks_next;
    lbps_ind_t              ind_reg;
    lbps_ind_t              ind_next;

    // result register
    logic      rsp_vld_reg;
    lbps_ind_t rsp_reg;

    logic rsp_free;
    logic apply;

    // result slot frees when empty or being taken
    assign rsp_free  = !rsp_vld_reg || !rsp_stall;
    assign apply     = req_vld_reg && rsp_free;
    assign req_stall = req_vld_reg && !rsp_free;

    lbps_eval #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_eval (
        .kind              (kind_reg),
        .new_system_state  (new_state_reg),
        .buzzer_ticks      (buzzer_ticks_reg),
        .led_ticks         (led_ticks_reg),
        .ind               (ind_reg),
        .buzzer_ticks_next (buzzer_ticks_next),
        .led_ticks_next    (led_ticks_next),
        .ind_next          (ind_next)
    );

    // Hold the request while its result cannot be written; otherwise take the next one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_vld_reg <= 1'b0;
        else if (!req_stall)
            req_vld_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
        begin
            kind_reg      <= kind;
            new_state_reg <= new_system_state;
        end
    end

    // Advance the sequencer state only when the request is applied.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buzzer_ticks_reg <= '0;
            led_ticks_reg    <= '0;
            ind_reg          <= '{buzzer: 1'b0, led_one: 1'b0, led_two: 1'b0,
                                  mode: MODE_NORMAL};
        end
        else if (apply)
        begin
            buzzer_ticks_reg <= buzzer_ticks_next;
            led_ticks_reg    <= led_ticks_next;
            ind_reg          <= ind_next;
        end
    end

    // Load the result when applied; drop valid once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_vld_reg <= 1'b0;
        else if (rsp_free)
            rsp_vld_reg <= apply;
    end

    always_ff @(posedge clk)
    begin
        if (apply)
            rsp_reg <= ind_next;
    end

    assign rsp_valid        = rsp_vld_reg;
    assign buzzer_on        = rsp_reg.buzzer;
    assign led_one_on       = rsp_reg.led_one;
    assign led_two_on       = rsp_reg.led_two;
    assign system_state_now = rsp_reg.mode;

endmodule
